FILE: hdl/aflt_pkg.sv
`timescale 1ns / 1ps

package aflt_pkg;

   localparam int SAMPLE_W = 16;
   localparam int LEAD_W   = 16;
   localparam int DELAY_W  = 5;
   localparam int CSR_W    = 16;

   typedef enum logic [1:0] {
      OP_SAMPLE = 2'd0,
      OP_START  = 2'd1,
      OP_END    = 2'd2,
      OP_STATUS = 2'd3
   } op_type;

   typedef enum logic [0:0] {
      REG_LEAD_SILENCE = 1'd0,
      REG_TRAIL_DELAY  = 1'd1
   } csr_index_type;

   // result of one transaction while the store read is in flight
   typedef struct packed {
      logic                       has_sample;
      logic                       frame_end;
      logic                       active;
      logic                       sel_store;
      logic signed [SAMPLE_W-1:0] value;
   } pend_type;

endpackage

FILE: hdl/aflt_store.sv
`timescale 1ns / 1ps

module aflt_store #(
   parameter int DEPTH = 2560,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read-first: a read of the address being written returns the old word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/audio_frame_lead_trail_trim_top.sv
`timescale 1ns / 1ps

// Frame-based audio gate. A start transaction arms the block and loads the leading
// silence count, an end transaction disarms it, a status transaction just reports the
// armed flag, and every request gives exactly one response. With a nonzero trailing
// delay D (saturated to MAX_FRAMES) the first D frames after start are only stored and
// later samples come out D frames late through a single MAX_FRAMES*FRAME_SAMPLES x 16
// store; with D zero samples pass straight through. The first leading_silence_frames
// emitted frames are zeroed. One request is taken every cycle while responses are not
// held back; a response sits in the pending register during the store read, then in the
// output register. The store is not cleared: after reset it is available at once.
// Configuration must be written only while no transaction is in flight (not enforced).

module audio_frame_lead_trail_trim_top #(
   parameter int MAX_FRAMES    = 16,
   parameter int FRAME_SAMPLES = 160
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  aflt_pkg::op_type                       req_op,
   input  logic signed [aflt_pkg::SAMPLE_W-1:0]   req_sample_in,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_has_sample,
   output logic signed [aflt_pkg::SAMPLE_W-1:0]   rsp_sample_out,
   output logic                                   rsp_frame_end,
   output logic                                   rsp_active,
   input  logic                                   csr_write_enable,
   input  aflt_pkg::csr_index_type                csr_index,
   input  logic [aflt_pkg::CSR_W-1:0]             csr_write_data
);

   import aflt_pkg::*;

   localparam int DEPTH = MAX_FRAMES * FRAME_SAMPLES;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int POS_W = $clog2(FRAME_SAMPLES + 1);

   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx,
                                                  input logic [CNT_W-1:0] limit);
      logic [CNT_W-1:0] n;
      n = CNT_W'(idx) + CNT_W'(1);
      return (n >= limit) ? '0 : n[IDX_W-1:0];
   endfunction

   function automatic logic [DELAY_W-1:0] sat_delay(input logic [DELAY_W-1:0] d);
      return (int'(d) > MAX_FRAMES) ? DELAY_W'(MAX_FRAMES) : d;
   endfunction

   // configuration
   logic [LEAD_W-1:0]  lead_ff;
   logic [DELAY_W-1:0] delay_ff;
   logic [CNT_W-1:0]   limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff  <= '0;
         delay_ff <= '0;
         limit_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_LEAD_SILENCE: lead_ff <= csr_write_data[LEAD_W-1:0];
            REG_TRAIL_DELAY: begin
               delay_ff <= sat_delay(csr_write_data[DELAY_W-1:0]);
               limit_ff <= CNT_W'(int'(sat_delay(csr_write_data[DELAY_W-1:0]))
                                  * FRAME_SAMPLES);
            end
            default: ;
         endcase
      end
   end

   // gate state
   logic               armed_ff, armed_in;
   logic [IDX_W-1:0]   wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [DELAY_W-1:0] filled_ff, filled_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [LEAD_W-1:0]  silence_ff, silence_in;

   // pipeline
   logic     pend_valid_ff, pend_valid_in;
   pend_type pend_ff, pend_in;
   logic     out_valid_ff, out_valid_in;
   pend_type out_ff, out_in;

   logic                accept;
   logic                move;
   logic                last;
   logic                st_wr_en;
   logic                st_rd_en;
   logic [SAMPLE_W-1:0] st_rd_data;

   assign move      = pend_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !pend_valid_ff || move;
   assign accept    = req_valid && req_ready;
   assign last      = (pos_ff == POS_W'(FRAME_SAMPLES - 1));

   always_comb begin
      armed_in   = armed_ff;
      wr_idx_in  = wr_idx_ff;
      rd_idx_in  = rd_idx_ff;
      filled_in  = filled_ff;
      pos_in     = pos_ff;
      silence_in = silence_ff;
      st_wr_en   = 1'b0;
      st_rd_en   = 1'b0;
      pend_in    = '0;
      if (accept) begin
         case (req_op)
            OP_START: begin
               armed_in   = 1'b1;
               wr_idx_in  = '0;
               rd_idx_in  = '0;
               filled_in  = '0;
               pos_in     = '0;
               silence_in = lead_ff;
            end
            OP_END: armed_in = 1'b0;
            OP_SAMPLE: begin
               if (armed_ff) begin
                  if (delay_ff == '0) begin
                     pend_in.has_sample = 1'b1;
                     pend_in.value      = (silence_ff != '0) ? '0 : req_sample_in;
                  end else if (filled_ff < delay_ff) begin
                     st_wr_en  = 1'b1;
                     wr_idx_in = ring_next(wr_idx_ff, limit_ff);
                     if (last) begin
                        filled_in = filled_ff + DELAY_W'(1);
                     end
                  end else begin
                     pend_in.has_sample = 1'b1;
                     pend_in.sel_store  = (silence_ff == '0);
                     st_wr_en  = 1'b1;
                     st_rd_en  = 1'b1;
                     rd_idx_in = ring_next(rd_idx_ff, limit_ff);
                     wr_idx_in = ring_next(wr_idx_ff, limit_ff);
                  end
                  if (pend_in.has_sample && last) begin
                     pend_in.frame_end = 1'b1;
                     if (silence_ff != '0) begin
                        silence_in = silence_ff - LEAD_W'(1);
                     end
                  end
                  pos_in = last ? '0 : pos_ff + POS_W'(1);
               end
            end
            OP_STATUS: ;
            default: ;
         endcase
      end
      pend_in.active = armed_in;
   end

   always_comb begin
      pend_valid_in = accept ? 1'b1 : (move ? 1'b0 : pend_valid_ff);
      out_valid_in  = move ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
      out_in        = pend_ff;
      if (pend_ff.sel_store) begin
         out_in.value = st_rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff      <= 1'b0;
         wr_idx_ff     <= '0;
         rd_idx_ff     <= '0;
         filled_ff     <= '0;
         pos_ff        <= '0;
         silence_ff    <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         armed_ff      <= armed_in;
         wr_idx_ff     <= wr_idx_in;
         rd_idx_ff     <= rd_idx_in;
         filled_ff     <= filled_in;
         pos_ff        <= pos_in;
         silence_ff    <= silence_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_ff <= pend_in;
      end
      if (move) begin
         out_ff <= out_in;
      end
   end

   aflt_store #(
      .DEPTH (DEPTH),
      .WIDTH (SAMPLE_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (wr_idx_ff),
      .wr_data (req_sample_in),
      .rd_en   (st_rd_en),
      .rd_addr (rd_idx_ff),
      .rd_data (st_rd_data)
   );

   assign rsp_valid      = out_valid_ff;
   assign rsp_has_sample = out_ff.has_sample;
   assign rsp_sample_out = out_ff.value;
   assign rsp_frame_end  = out_ff.frame_end;
   assign rsp_active     = out_ff.active;

`ifndef NO_ASSERTIONS
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !(accept && pend_valid_ff && out_valid_ff && !rsp_ready))
      else $error("request taken while both stages are stalled");

   a_empty_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_sample |-> rsp_sample_out == '0 && !rsp_frame_end)
      else $error("response without sample carries data");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      int'(wr_idx_ff) < DEPTH && int'(rd_idx_ff) < DEPTH)
      else $error("store index out of range");

   // the fill count may stay above a lowered delay, but never passes the store size
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      int'(filled_ff) <= MAX_FRAMES)
      else $error("fill count beyond store size");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      int'(pos_ff) < FRAME_SAMPLES)
      else $error("frame position out of range");
`endif

endmodule
